// ===== rtl/core/egsp_pkg.sv =====
// Shared constants, types, the command enum and the status struct for the shortest-path block.
package egsp_pkg;

    localparam int MAX_CITIES = 64;
    localparam int IDX_W      = $clog2(MAX_CITIES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int COORD_W    = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int FRAC_W     = 16;
    localparam int RAD_W      = SQ_W + FRAC_W;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int REM_W      = ROOT_W + 3;
    localparam int STEP_W     = $clog2(ROOT_W + 1);
    localparam int DIST_W     = 32;

    typedef enum logic [1:0] {
        OPC_POS   = 2'd0,
        OPC_ADD   = 2'd1,
        OPC_DEL   = 2'd2,
        OPC_QUERY = 2'd3
    } item_op_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_POS_WR,
        OP_ROW_RD_A, OP_ROW_WR_A, OP_ROW_RD_B, OP_ROW_WR_B,
        OP_Q_INIT, OP_SCAN_INIT, OP_SCAN_RD, OP_SCAN_SKIP, OP_SCAN_CMP,
        OP_SETTLE, OP_SETTLE_LATCH, OP_RELAX_RD, OP_NEXT,
        OP_DIFF, OP_SQ, OP_SUM, OP_RELAX_UPD,
        OP_TRACE_INIT, OP_TRACE_DIST, OP_TRACE_STEP, OP_TRACE_NEXT,
        OP_EMIT_RD, OP_EMIT, OP_FAIL
    } dp_op_t;

    typedef struct packed {
        item_op_t item_op;
        logic     road_ok;
        logic     query_ok;
        logic     idx_end;
        logic     cand;
        logic     best_found;
        logic     nbr;
        logic     sqrt_busy;
        logic     reached_dst;
        logic     trace_stop;
        logic     emit_last;
        logic     out_free;
    } egsp_status_t;

endpackage

// ===== rtl/core/egsp_isqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
module egsp_isqrt import egsp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              busy,
    output logic [ROOT_W-1:0] root
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [RAD_W-1:0]  val_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    assign rem_sh    = {rem_reg[REM_W-3:0], val_reg[RAD_W-1 -: 2]};
    assign trial     = REM_W'({root_reg, 2'b01});
    assign busy_next = start ? 1'b1 : (busy_reg && step_reg != STEP_W'(1)) ? 1'b1 : 1'b0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            val_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            step_reg <= STEP_W'(ROOT_W);
        end else if (busy_reg) begin
            val_reg  <= {val_reg[RAD_W-3:0], 2'b00};
            step_reg <= step_reg - 1'b1;
            if (rem_sh >= trial) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ===== rtl/core/egsp_dp.sv =====
// Datapath: city and road stores, search state, edge length and result register.
module egsp_dp import egsp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [47:0]  s_tdata,
    input  logic         cfg_valid,
    input  logic [7:0]   cfg_data,
    input  dp_op_t       cmd,
    output egsp_status_t status,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,
    output logic [0:0]   m_tuser,
    output logic         m_tlast
);

    // stores
    logic signed [COORD_W-1:0] x_mem [MAX_CITIES];
    logic signed [COORD_W-1:0] y_mem [MAX_CITIES];
    logic [MAX_CITIES-1:0]     row_mem [MAX_CITIES];
    logic [DIST_W-1:0]         bd_mem [MAX_CITIES];
    logic [IDX_W-1:0]          pred_mem [MAX_CITIES];
    logic [IDX_W-1:0]          path_mem [MAX_CITIES];

    logic [CNT_W-1:0]          count_reg;
    logic [MAX_CITIES-1:0]     row_valid_reg;
    logic [MAX_CITIES-1:0]     pos_valid_reg;
    logic [MAX_CITIES-1:0]     reached_reg, settled_reg;

    item_op_t                  op_reg;
    logic [IDX_W-1:0]          a_reg, b_reg;
    logic signed [COORD_W-1:0] cx_reg, cy_reg;

    logic signed [COORD_W-1:0] xr_reg, yr_reg, ux_reg, uy_reg;
    logic [MAX_CITIES-1:0]     row_rd_reg;
    logic [DIST_W-1:0]         bd_rd_reg, best_d_reg, u_dist_reg, dist_reg;
    logic [IDX_W-1:0]          pred_rd_reg, path_rd_reg;
    logic [CNT_W-1:0]          i_reg, len_reg;
    logic [IDX_W-1:0]          best_u_reg, u_reg, tv_reg;
    logic                      best_found_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg;
    logic [SQ_W-1:0]           sqx_reg, sqy_reg;

    logic                      m_valid_reg;
    logic [IDX_W-1:0]          m_node_reg;
    logic [DIST_W-1:0]         m_dist_reg;
    logic                      m_found_reg, m_last_reg;

    logic [CNT_W-1:0]          n_w;
    logic [IDX_W-1:0]          i_idx;
    logic                      pos_ok;
    logic [MAX_CITIES-1:0]     bit_a, bit_b;
    logic [SQ_W:0]             sq_sum;
    logic [RAD_W-1:0]          radicand;
    logic                      sqrt_busy;
    logic [ROOT_W-1:0]         root;
    logic [DIST_W:0]           sum_wide;
    logic [DIST_W-1:0]         nd;
    logic                      upd;
    logic [CNT_W-1:0]          len_m1, len_p1;

    assign n_w    = (count_reg > CNT_W'(MAX_CITIES)) ? CNT_W'(MAX_CITIES) : count_reg;
    assign i_idx  = i_reg[IDX_W-1:0];
    assign pos_ok = ({1'b0, a_reg} < n_w);
    assign bit_a  = MAX_CITIES'(1) << a_reg;
    assign bit_b  = MAX_CITIES'(1) << b_reg;
    assign sq_sum = (SQ_W+1)'(sqx_reg) + (SQ_W+1)'(sqy_reg);
    assign radicand = RAD_W'({sq_sum, FRAC_W'(0)});
    assign sum_wide = (DIST_W+1)'(u_dist_reg) + (DIST_W+1)'(root);
    assign nd     = sum_wide[DIST_W] ? '1 : sum_wide[DIST_W-1:0];
    assign upd    = !reached_reg[i_idx] || (nd < bd_rd_reg);
    assign len_m1 = len_reg - 1'b1;
    assign len_p1 = len_reg + 1'b1;

    egsp_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd == OP_SUM),
        .radicand (radicand),
        .busy     (sqrt_busy),
        .root     (root)
    );

    always_comb begin
        status.item_op     = op_reg;
        status.road_ok     = ({1'b0, a_reg} < n_w) && ({1'b0, b_reg} < n_w) && (a_reg != b_reg);
        status.query_ok    = ({1'b0, a_reg} < n_w) && ({1'b0, b_reg} < n_w);
        status.idx_end     = (i_reg >= n_w);
        status.cand        = reached_reg[i_idx] && !settled_reg[i_idx];
        status.best_found  = best_found_reg;
        status.nbr         = row_rd_reg[i_idx] && (i_idx != u_reg);
        status.sqrt_busy   = sqrt_busy;
        status.reached_dst = reached_reg[b_reg];
        status.trace_stop  = (tv_reg == a_reg) || (len_p1 >= n_w);
        status.emit_last   = (len_reg == '0);
        status.out_free    = !m_valid_reg || m_tready;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            row_valid_reg <= '0;
            pos_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                count_reg <= cfg_data[CNT_W-1:0];
            end
            if (cmd == OP_ROW_WR_A) begin
                row_valid_reg[a_reg] <= 1'b1;
            end else if (cmd == OP_ROW_WR_B) begin
                row_valid_reg[b_reg] <= 1'b1;
            end
            if (cmd == OP_POS_WR && pos_ok) begin
                pos_valid_reg[a_reg] <= 1'b1;
            end
            if (cmd == OP_EMIT || cmd == OP_FAIL) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // city positions; an unwritten position reads as the origin
    always_ff @(posedge aclk) begin
        if (cmd == OP_POS_WR && pos_ok) begin
            x_mem[a_reg] <= cx_reg;
            y_mem[a_reg] <= cy_reg;
        end
        if (cmd == OP_SETTLE) begin
            xr_reg <= pos_valid_reg[best_u_reg] ? x_mem[best_u_reg] : '0;
            yr_reg <= pos_valid_reg[best_u_reg] ? y_mem[best_u_reg] : '0;
        end else if (cmd == OP_RELAX_RD) begin
            xr_reg <= pos_valid_reg[i_idx] ? x_mem[i_idx] : '0;
            yr_reg <= pos_valid_reg[i_idx] ? y_mem[i_idx] : '0;
        end
    end

    // road rows; an unwritten row reads empty
    always_ff @(posedge aclk) begin
        if (cmd == OP_ROW_WR_A) begin
            row_mem[a_reg] <= (op_reg == OPC_ADD) ? (row_rd_reg | bit_b) : (row_rd_reg & ~bit_b);
        end else if (cmd == OP_ROW_WR_B) begin
            row_mem[b_reg] <= (op_reg == OPC_ADD) ? (row_rd_reg | bit_a) : (row_rd_reg & ~bit_a);
        end
        if (cmd == OP_ROW_RD_A) begin
            row_rd_reg <= row_valid_reg[a_reg] ? row_mem[a_reg] : '0;
        end else if (cmd == OP_ROW_RD_B) begin
            row_rd_reg <= row_valid_reg[b_reg] ? row_mem[b_reg] : '0;
        end else if (cmd == OP_SETTLE) begin
            row_rd_reg <= row_valid_reg[best_u_reg] ? row_mem[best_u_reg] : '0;
        end
    end

    // distances and predecessors
    always_ff @(posedge aclk) begin
        if (cmd == OP_Q_INIT) begin
            bd_mem[a_reg] <= '0;
        end else if (cmd == OP_RELAX_UPD && upd) begin
            bd_mem[i_idx]   <= nd;
            pred_mem[i_idx] <= u_reg;
        end
        if (cmd == OP_SCAN_RD || cmd == OP_RELAX_RD) begin
            bd_rd_reg <= bd_mem[i_idx];
        end else if (cmd == OP_TRACE_INIT) begin
            bd_rd_reg <= bd_mem[b_reg];
        end
        if (cmd == OP_TRACE_STEP) begin
            pred_rd_reg <= pred_mem[tv_reg];
        end
    end

    // path buffer
    always_ff @(posedge aclk) begin
        if (cmd == OP_TRACE_STEP) begin
            path_mem[len_reg[IDX_W-1:0]] <= tv_reg;
        end
        if (cmd == OP_EMIT_RD) begin
            path_rd_reg <= path_mem[len_m1[IDX_W-1:0]];
        end
    end

    // search and arithmetic registers
    always_ff @(posedge aclk) begin
        unique case (cmd)
            OP_LOAD: begin
                op_reg <= item_op_t'(s_tdata[1:0]);
                a_reg  <= s_tdata[7:2];
                b_reg  <= s_tdata[13:8];
                cx_reg <= s_tdata[29:14];
                cy_reg <= s_tdata[45:30];
            end
            OP_Q_INIT: begin
                reached_reg    <= bit_a;
                settled_reg    <= '0;
                i_reg          <= '0;
                best_found_reg <= 1'b0;
            end
            OP_SCAN_INIT: begin
                i_reg          <= '0;
                best_found_reg <= 1'b0;
            end
            OP_SCAN_SKIP, OP_NEXT: begin
                i_reg <= i_reg + 1'b1;
            end
            OP_SCAN_CMP: begin
                if (!best_found_reg || bd_rd_reg < best_d_reg) begin
                    best_found_reg <= 1'b1;
                    best_d_reg     <= bd_rd_reg;
                    best_u_reg     <= i_idx;
                end
                i_reg <= i_reg + 1'b1;
            end
            OP_SETTLE: begin
                settled_reg[best_u_reg] <= 1'b1;
                u_reg      <= best_u_reg;
                u_dist_reg <= best_d_reg;
                i_reg      <= '0;
            end
            OP_SETTLE_LATCH: begin
                ux_reg <= xr_reg;
                uy_reg <= yr_reg;
            end
            OP_DIFF: begin
                dx_reg <= DIFF_W'(ux_reg) - DIFF_W'(xr_reg);
                dy_reg <= DIFF_W'(uy_reg) - DIFF_W'(yr_reg);
            end
            OP_SQ: begin
                sqx_reg <= SQ_W'(dx_reg * dx_reg);
                sqy_reg <= SQ_W'(dy_reg * dy_reg);
            end
            OP_RELAX_UPD: begin
                if (upd) begin
                    reached_reg[i_idx] <= 1'b1;
                end
                i_reg <= i_reg + 1'b1;
            end
            OP_TRACE_INIT: begin
                tv_reg  <= b_reg;
                len_reg <= '0;
            end
            OP_TRACE_DIST: begin
                dist_reg <= bd_rd_reg;
            end
            OP_TRACE_STEP: begin
                len_reg <= len_p1;
            end
            OP_TRACE_NEXT: begin
                tv_reg <= pred_rd_reg;
            end
            OP_EMIT_RD: begin
                len_reg <= len_m1;
            end
            OP_EMIT: begin
                m_node_reg  <= path_rd_reg;
                m_dist_reg  <= dist_reg;
                m_found_reg <= 1'b1;
                m_last_reg  <= (len_reg == '0);
            end
            OP_FAIL: begin
                m_node_reg  <= '0;
                m_dist_reg  <= '0;
                m_found_reg <= 1'b0;
                m_last_reg  <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_dist_reg, m_node_reg};
    assign m_tuser  = m_found_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== rtl/core/egsp_ctrl.sv =====
// Controller state machine sequencing updates, Dijkstra search, trace and output.
module egsp_ctrl import egsp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  egsp_status_t status,
    output dp_op_t       cmd
);

    typedef enum logic [22:0] {
        S_IDLE         = 23'd1 << 0,
        S_DISPATCH     = 23'd1 << 1,
        S_ROW_RD_A     = 23'd1 << 2,
        S_ROW_WR_A     = 23'd1 << 3,
        S_ROW_RD_B     = 23'd1 << 4,
        S_ROW_WR_B     = 23'd1 << 5,
        S_Q_INIT       = 23'd1 << 6,
        S_SCAN         = 23'd1 << 7,
        S_SCAN_CMP     = 23'd1 << 8,
        S_SETTLE_LATCH = 23'd1 << 9,
        S_RELAX_CHK    = 23'd1 << 10,
        S_RELAX_DIFF   = 23'd1 << 11,
        S_RELAX_SQ     = 23'd1 << 12,
        S_RELAX_SUM    = 23'd1 << 13,
        S_RELAX_SQRT   = 23'd1 << 14,
        S_RELAX_UPD    = 23'd1 << 15,
        S_TRACE_START  = 23'd1 << 16,
        S_TRACE_DIST   = 23'd1 << 17,
        S_TRACE_STEP   = 23'd1 << 18,
        S_TRACE_NEXT   = 23'd1 << 19,
        S_EMIT_RD      = 23'd1 << 20,
        S_EMIT_OUT     = 23'd1 << 21,
        S_FAIL_OUT     = 23'd1 << 22
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd        = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (status.item_op)
                    OPC_POS: begin
                        cmd        = OP_POS_WR;
                        state_next = S_IDLE;
                    end
                    OPC_ADD, OPC_DEL: begin
                        state_next = status.road_ok ? S_ROW_RD_A : S_IDLE;
                    end
                    default: begin
                        state_next = status.query_ok ? S_Q_INIT : S_FAIL_OUT;
                    end
                endcase
            end
            S_ROW_RD_A: begin
                cmd        = OP_ROW_RD_A;
                state_next = S_ROW_WR_A;
            end
            S_ROW_WR_A: begin
                cmd        = OP_ROW_WR_A;
                state_next = S_ROW_RD_B;
            end
            S_ROW_RD_B: begin
                cmd        = OP_ROW_RD_B;
                state_next = S_ROW_WR_B;
            end
            S_ROW_WR_B: begin
                cmd        = OP_ROW_WR_B;
                state_next = S_IDLE;
            end
            S_Q_INIT: begin
                cmd        = OP_Q_INIT;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (status.idx_end) begin
                    if (status.best_found) begin
                        cmd        = OP_SETTLE;
                        state_next = S_SETTLE_LATCH;
                    end else begin
                        state_next = S_TRACE_START;
                    end
                end else if (status.cand) begin
                    cmd        = OP_SCAN_RD;
                    state_next = S_SCAN_CMP;
                end else begin
                    cmd = OP_SCAN_SKIP;
                end
            end
            S_SCAN_CMP: begin
                cmd        = OP_SCAN_CMP;
                state_next = S_SCAN;
            end
            S_SETTLE_LATCH: begin
                cmd        = OP_SETTLE_LATCH;
                state_next = S_RELAX_CHK;
            end
            S_RELAX_CHK: begin
                if (status.idx_end) begin
                    cmd        = OP_SCAN_INIT;
                    state_next = S_SCAN;
                end else if (status.nbr) begin
                    cmd        = OP_RELAX_RD;
                    state_next = S_RELAX_DIFF;
                end else begin
                    cmd = OP_NEXT;
                end
            end
            S_RELAX_DIFF: begin
                cmd        = OP_DIFF;
                state_next = S_RELAX_SQ;
            end
            S_RELAX_SQ: begin
                cmd        = OP_SQ;
                state_next = S_RELAX_SUM;
            end
            S_RELAX_SUM: begin
                cmd        = OP_SUM;
                state_next = S_RELAX_SQRT;
            end
            S_RELAX_SQRT: begin
                if (!status.sqrt_busy) begin
                    state_next = S_RELAX_UPD;
                end
            end
            S_RELAX_UPD: begin
                cmd        = OP_RELAX_UPD;
                state_next = S_RELAX_CHK;
            end
            S_TRACE_START: begin
                if (status.reached_dst) begin
                    cmd        = OP_TRACE_INIT;
                    state_next = S_TRACE_DIST;
                end else begin
                    state_next = S_FAIL_OUT;
                end
            end
            S_TRACE_DIST: begin
                cmd        = OP_TRACE_DIST;
                state_next = S_TRACE_STEP;
            end
            S_TRACE_STEP: begin
                cmd        = OP_TRACE_STEP;
                state_next = status.trace_stop ? S_EMIT_RD : S_TRACE_NEXT;
            end
            S_TRACE_NEXT: begin
                cmd        = OP_TRACE_NEXT;
                state_next = S_TRACE_STEP;
            end
            S_EMIT_RD: begin
                cmd        = OP_EMIT_RD;
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (status.out_free) begin
                    cmd        = OP_EMIT;
                    state_next = status.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            S_FAIL_OUT: begin
                if (status.out_free) begin
                    cmd        = OP_FAIL;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/euclidean_graph_shortest_path_top.sv =====
// Top level: city road graph with Dijkstra shortest-path queries.
// Operation: a query repeatedly scans the distance memory for the nearest reached, unsettled
//   city, settles it and relaxes each of its roads, then traces the path back from the
//   destination and emits one result per path node; output back-pressure can stall it.
// Throughput: one item at a time; the query time is set by the serial minimum scan over
//   the distance memory and the one-bit-per-cycle square root of each relaxed road.
// Reset (aresetn, synchronous, active low) clears city count, road rows and positions
//   (per-entry valid bits, so unwritten entries read empty or zero), FSM and output valid.
module euclidean_graph_shortest_path_top import egsp_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // input transaction: tdata = opcode[1:0], first_index[7:2], second_index[13:8],
    //                            coord_x[29:14], coord_y[45:30], zero fill
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,
    // city_count register write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data,
    // result transaction: tdata = path_node[5:0], total_distance[37:6], zero fill
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,
    output logic [0:0]   m_tuser,   // found[0]
    output logic         m_tlast
);

    dp_op_t       cmd;
    egsp_status_t status;

    // The count register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    egsp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Stores, search registers, square-root unit and the output register.
    egsp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
